### rtl/core/mpbc_pkg.sv
// ----------------------------------------------------------------------------
// mpbc_pkg
// Shared types and constants for the molecule pair bond classifier.
// ----------------------------------------------------------------------------
package mpbc_pkg;

   localparam int BOX_BITS   = 20;
   localparam int CUT_BITS   = 44;
   localparam int CSR_IDX_W  = 3;
   localparam int N_HYD      = 2;
   localparam int N_TGT      = 4;
   localparam int N_PAIR     = N_HYD * N_TGT;

   localparam logic [CSR_IDX_W-1:0] REG_PERIODIC   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_BOX_X      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_BOX_Y      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_BOX_Z      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_BOND_CUT   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_STRICT_CUT = 3'd5;

   typedef enum logic [1:0] {
      CLASS_NONE   = 2'd0,
      CLASS_WEAK   = 2'd1,
      CLASS_STRONG = 2'd2
   } bond_class_type;

   typedef logic [2:0][BOX_BITS-1:0] box_set_type;

   typedef struct packed {
      logic diff;
      logic square;
      logic compare;
   } stage_en_type;

endpackage

### rtl/core/mpbc_lane.sv
// ----------------------------------------------------------------------------
// mpbc_lane
// One pair distance lane: minimum image difference, squares, sum and cutoff
// compare, three register stages.
// ----------------------------------------------------------------------------
module mpbc_lane
   import mpbc_pkg::*;
#(
   parameter int COORD_BITS = 20
) (
   input  logic                    clock,
   input  stage_en_type            en,
   input  logic [3*COORD_BITS-1:0] p_one,
   input  logic [3*COORD_BITS-1:0] p_two,
   input  logic                    periodic,
   input  box_set_type             box,
   input  logic [CUT_BITS-1:0]     cutoff,
   output logic                    hit
);

   localparam int DW   = COORD_BITS + 1;
   localparam int WW   = ((COORD_BITS > BOX_BITS) ? COORD_BITS : BOX_BITS) + 3;
   localparam int SW   = 2 * COORD_BITS;
   localparam int SUMW = SW + 2;
   localparam int CW   = (SUMW > CUT_BITS) ? SUMW : CUT_BITS;

   logic signed [DW-1:0] d_in  [3];
   logic signed [DW-1:0] d_ff  [3];
   logic        [SW-1:0] sq_in [3];
   logic        [SW-1:0] sq_ff [3];
   logic [SUMW-1:0]      sum;
   logic                 hit_in;
   logic                 hit_ff;

   for (genvar ax = 0; ax < 3; ax++) begin : g_axis
      logic signed [WW-1:0]   diff;
      logic signed [WW-1:0]   two_d;
      logic signed [WW-1:0]   bx;
      logic signed [WW-1:0]   res;
      logic signed [2*DW-1:0] prod;

      always_comb begin
         diff  = signed'(WW'(p_one[ax*COORD_BITS +: COORD_BITS]))
               - signed'(WW'(p_two[ax*COORD_BITS +: COORD_BITS]));
         two_d = diff <<< 1;
         bx    = signed'(WW'(box[ax]));
         res   = diff;
         if (periodic && (two_d > bx)) begin
            res = diff - bx;
         end else if (periodic && (two_d < -bx)) begin
            res = diff + bx;
         end
         d_in[ax] = DW'(res);
      end

      always_comb begin
         prod      = d_ff[ax] * d_ff[ax];
         sq_in[ax] = prod[SW-1:0];
      end

      always_ff @(posedge clock) begin
         if (en.diff) begin
            d_ff[ax] <= d_in[ax];
         end
         if (en.square) begin
            sq_ff[ax] <= sq_in[ax];
         end
      end
   end

   always_comb begin
      sum    = SUMW'(sq_ff[0]) + SUMW'(sq_ff[1]) + SUMW'(sq_ff[2]);
      hit_in = CW'(sum) < CW'(cutoff);
   end

   always_ff @(posedge clock) begin
      if (en.compare) begin
         hit_ff <= hit_in;
      end
   end

   assign hit = hit_ff;

endmodule

### rtl/core/mpbc_merge.sv
// ----------------------------------------------------------------------------
// mpbc_merge
// Combines lane hits into the bond class and strict flag; output register.
// ----------------------------------------------------------------------------
module mpbc_merge
   import mpbc_pkg::*;
(
   input  logic              clock,
   input  logic              load,
   input  logic [N_PAIR-1:0] bond_hit,
   input  logic [N_PAIR-1:0] strict_hit,
   input  logic              same_molecule,
   output bond_class_type    bond_class,
   output logic              strict_bond
);

   logic           strong_any;
   logic           weak_any;
   bond_class_type class_in;
   bond_class_type class_ff;
   logic           strict_ff;

   // pair index is hydrogen * N_TGT + target; targets 0,1 double, 2,3 hydroxyl
   always_comb begin
      strong_any = 1'b0;
      weak_any   = 1'b0;
      for (int h = 0; h < N_HYD; h++) begin
         strong_any = strong_any | bond_hit[h*N_TGT] | bond_hit[h*N_TGT+1];
         weak_any   = weak_any | bond_hit[h*N_TGT+2] | bond_hit[h*N_TGT+3];
      end
      if (same_molecule) begin
         class_in = CLASS_NONE;
      end else if (strong_any) begin
         class_in = CLASS_STRONG;
      end else if (weak_any) begin
         class_in = CLASS_WEAK;
      end else begin
         class_in = CLASS_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         class_ff  <= class_in;
         strict_ff <= |(bond_hit & strict_hit);
      end
   end

   assign bond_class  = class_ff;
   assign strict_bond = strict_ff;

endmodule

### rtl/core/molecule_pair_bond_classifier_unit.sv
// ----------------------------------------------------------------------------
// molecule_pair_bond_classifier_unit
// Hydrogen bond contact classifier for one molecule pair per beat.
//
//  channel | dir | handshake          | payload
//  req     | in  | req_valid/ready    | same_molecule, eight packed positions
//  rsp     | out | rsp_valid/ready    | bond_class, strict_bond
//  csr     | in  | csr_we             | csr_index, csr_wdata
//
// One beat per cycle sustained while the output is not stalled; stages are
// difference, square, sum/compare, merge. Sixteen distance lanes run in parallel.
// Each stage loads when empty or when the next stage moves on, so bubbles
// close up while the output is stalled.
// Synchronous reset clears valid bits, box and cutoff registers and sets periodic mode.
// ----------------------------------------------------------------------------
module molecule_pair_bond_classifier_unit
   import mpbc_pkg::*;
#(
   parameter int COORD_BITS = 20
) (
   input  logic                    clock,
   input  logic                    reset,

   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic                    req_same_molecule,
   input  logic [3*COORD_BITS-1:0] req_a_hydrogen_one,
   input  logic [3*COORD_BITS-1:0] req_a_hydrogen_two,
   input  logic [3*COORD_BITS-1:0] req_a_hydroxyl_one,
   input  logic [3*COORD_BITS-1:0] req_a_hydroxyl_two,
   input  logic [3*COORD_BITS-1:0] req_b_double_one,
   input  logic [3*COORD_BITS-1:0] req_b_double_two,
   input  logic [3*COORD_BITS-1:0] req_b_hydroxyl_one,
   input  logic [3*COORD_BITS-1:0] req_b_hydroxyl_two,

   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [1:0]              rsp_bond_class,
   output logic                    rsp_strict_bond,

   input  logic                    csr_we,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [CUT_BITS-1:0]     csr_wdata
);

   localparam int PW = 3 * COORD_BITS;

   logic                periodic_ff, periodic_in;
   box_set_type         box_ff, box_in;
   logic [CUT_BITS-1:0] bond_cut_ff, bond_cut_in;
   logic [CUT_BITS-1:0] strict_cut_ff, strict_cut_in;

   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic v1_in, v2_in, v3_in, v4_in;
   logic en1, en2, en3, en4;
   logic same1_ff, same2_ff, same3_ff;
   stage_en_type lane_en;

   logic [PW-1:0] hyd [N_HYD];
   logic [PW-1:0] own [N_HYD];
   logic [PW-1:0] tgt [N_TGT];
   logic [N_PAIR-1:0] bond_hit;
   logic [N_PAIR-1:0] strict_hit;
   bond_class_type    class_out;

   // configuration
   always_comb begin
      periodic_in   = periodic_ff;
      box_in        = box_ff;
      bond_cut_in   = bond_cut_ff;
      strict_cut_in = strict_cut_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_PERIODIC:   periodic_in   = csr_wdata[0];
            REG_BOX_X:      box_in[0]     = csr_wdata[BOX_BITS-1:0];
            REG_BOX_Y:      box_in[1]     = csr_wdata[BOX_BITS-1:0];
            REG_BOX_Z:      box_in[2]     = csr_wdata[BOX_BITS-1:0];
            REG_BOND_CUT:   bond_cut_in   = csr_wdata;
            REG_STRICT_CUT: strict_cut_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         periodic_ff   <= 1'b1;
         box_ff        <= '0;
         bond_cut_ff   <= '0;
         strict_cut_ff <= '0;
      end else begin
         periodic_ff   <= periodic_in;
         box_ff        <= box_in;
         bond_cut_ff   <= bond_cut_in;
         strict_cut_ff <= strict_cut_in;
      end
   end

   // pipeline control
   always_comb begin
      en4   = !v4_ff || rsp_ready;
      en3   = !v3_ff || en4;
      en2   = !v2_ff || en3;
      en1   = !v1_ff || en2;
      v1_in = en1 ? req_valid : v1_ff;
      v2_in = en2 ? v1_ff : v2_ff;
      v3_in = en3 ? v2_ff : v3_ff;
      v4_in = en4 ? v3_ff : v4_ff;
      lane_en.diff    = en1;
      lane_en.square  = en2;
      lane_en.compare = en3;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         v4_ff <= v4_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         same1_ff <= req_same_molecule;
      end
      if (en2) begin
         same2_ff <= same1_ff;
      end
      if (en3) begin
         same3_ff <= same2_ff;
      end
   end

   assign req_ready = en1;
   assign rsp_valid = v4_ff;

   // lanes
   assign hyd[0] = req_a_hydrogen_one;
   assign hyd[1] = req_a_hydrogen_two;
   assign own[0] = req_a_hydroxyl_one;
   assign own[1] = req_a_hydroxyl_two;
   assign tgt[0] = req_b_double_one;
   assign tgt[1] = req_b_double_two;
   assign tgt[2] = req_b_hydroxyl_one;
   assign tgt[3] = req_b_hydroxyl_two;

   for (genvar h = 0; h < N_HYD; h++) begin : g_hyd
      for (genvar t = 0; t < N_TGT; t++) begin : g_tgt
         mpbc_lane #(.COORD_BITS(COORD_BITS)) u_bond (
            .clock    (clock),
            .en       (lane_en),
            .p_one    (hyd[h]),
            .p_two    (tgt[t]),
            .periodic (periodic_ff),
            .box      (box_ff),
            .cutoff   (bond_cut_ff),
            .hit      (bond_hit[h*N_TGT+t])
         );

         mpbc_lane #(.COORD_BITS(COORD_BITS)) u_strict (
            .clock    (clock),
            .en       (lane_en),
            .p_one    (own[h]),
            .p_two    (tgt[t]),
            .periodic (periodic_ff),
            .box      (box_ff),
            .cutoff   (strict_cut_ff),
            .hit      (strict_hit[h*N_TGT+t])
         );
      end
   end

   mpbc_merge u_merge (
      .clock         (clock),
      .load          (en4),
      .bond_hit      (bond_hit),
      .strict_hit    (strict_hit),
      .same_molecule (same3_ff),
      .bond_class    (class_out),
      .strict_bond   (rsp_strict_bond)
   );

   assign rsp_bond_class = class_out;

   // checks
   a_empty_out_ready : assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with empty output stage");

   a_stage3_held : assert property (@(posedge clock) disable iff (reset)
      (v3_ff && v4_ff && !rsp_ready) |=> v3_ff)
      else $error("stage 3 beat dropped while output stalled");

   a_accept_fills : assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> v1_ff)
      else $error("accepted beat not captured in first stage");

endmodule

### dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the molecule pair bond classifier.
// A short table of hand-picked pairs and register writes is run first,
// followed by random pairs over several box and cutoff settings. An
// in-bench model predicts class and strict flag for each accepted beat
// not pinned by the table; results are checked against them in order.
// Both handshakes idle and stall at random, with one long output hold-off.
// ----------------------------------------------------------------------------
module tb
   import mpbc_pkg::*;
();

   localparam int COORD_W        = 20;
   localparam int POS_W          = 3 * COORD_W;
   localparam int PIPE_DEPTH     = 4;
   localparam int HOLD_CYCLES    = 300;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int PHASES         = 8;
   localparam int PHASE_BEATS    = 60;

   localparam logic [BOX_BITS-1:0] BOX_MAX = {BOX_BITS{1'b1}};
   localparam logic [CUT_BITS-1:0] CUT_MAX = {CUT_BITS{1'b1}};
   localparam logic [POS_W-1:0]    ONES    = {POS_W{1'b1}};

   typedef logic [POS_W-1:0] pos_type;

   typedef struct packed {
      logic                  same;
      logic [1:0][POS_W-1:0] hyd;
      logic [1:0][POS_W-1:0] own;
      logic [3:0][POS_W-1:0] tgt;   // double one, double two, hydroxyl one, hydroxyl two
   } pair_type;

   typedef struct packed {
      logic                periodic;
      box_set_type         box;
      logic [CUT_BITS-1:0] bond_cut;
      logic [CUT_BITS-1:0] strict_cut;
   } cfg_type;

   typedef struct packed {
      bond_class_type cls;
      logic           strict;
   } verdict_type;

   typedef struct packed {
      logic        pinned;
      verdict_type want;
   } pin_type;

   typedef struct packed {
      logic                 is_reg;
      logic [CSR_IDX_W-1:0] idx;
      logic [CUT_BITS-1:0]  data;
      pair_type             pair;
      logic                 pinned;
      verdict_type          want;
   } stim_row_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic                 req_same_molecule = 1'b0;
   pos_type              req_a_hydrogen_one = '0;
   pos_type              req_a_hydrogen_two = '0;
   pos_type              req_a_hydroxyl_one = '0;
   pos_type              req_a_hydroxyl_two = '0;
   pos_type              req_b_double_one = '0;
   pos_type              req_b_double_two = '0;
   pos_type              req_b_hydroxyl_one = '0;
   pos_type              req_b_hydroxyl_two = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [1:0]           rsp_bond_class;
   logic                 rsp_strict_bond;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CUT_BITS-1:0]  csr_wdata = '0;

   cfg_type      live_cfg;
   verdict_type  due_verdicts[$];
   pin_type      pinned_verdicts[$];
   stim_row_type stim_table[$];
   int           failures = 0;
   int           quiet_cycles = 0;
   logic         send_calm = 1'b0;
   logic         sink_calm = 1'b0;
   logic         hold_asked = 1'b0;

   molecule_pair_bond_classifier_unit #(.COORD_BITS(COORD_W)) dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_same_molecule  (req_same_molecule),
      .req_a_hydrogen_one (req_a_hydrogen_one),
      .req_a_hydrogen_two (req_a_hydrogen_two),
      .req_a_hydroxyl_one (req_a_hydroxyl_one),
      .req_a_hydroxyl_two (req_a_hydroxyl_two),
      .req_b_double_one   (req_b_double_one),
      .req_b_double_two   (req_b_double_two),
      .req_b_hydroxyl_one (req_b_hydroxyl_one),
      .req_b_hydroxyl_two (req_b_hydroxyl_two),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_bond_class     (rsp_bond_class),
      .rsp_strict_bond    (rsp_strict_bond),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // ---------------------------------------------------------------- model

   function automatic longint axis_delta(pos_type p, pos_type q, int axis, cfg_type c);
      longint d;
      longint len;
      d   = longint'(p[COORD_W*axis +: COORD_W]) - longint'(q[COORD_W*axis +: COORD_W]);
      len = longint'(c.box[axis]);
      if (c.periodic) begin
         if (2 * d > len)
            d = d - len;
         else if (2 * d < -len)
            d = d + len;
      end
      return d;
   endfunction

   function automatic longint sep_sq(pos_type p, pos_type q, cfg_type c);
      longint acc;
      longint d;
      acc = 0;
      for (int a = 0; a < 3; a++) begin
         d   = axis_delta(p, q, a, c);
         acc = acc + d * d;
      end
      return acc;
   endfunction

   function automatic verdict_type classify_pair(pair_type p, cfg_type c);
      verdict_type v;
      logic        strong_any;
      logic        weak_any;
      strong_any = 1'b0;
      weak_any   = 1'b0;
      v.strict   = 1'b0;
      for (int h = 0; h < N_HYD; h++) begin
         for (int t = 0; t < N_TGT; t++) begin
            if (sep_sq(p.hyd[h], p.tgt[t], c) < longint'(c.bond_cut)) begin
               if (t < 2)
                  strong_any = 1'b1;
               else
                  weak_any = 1'b1;
               if (sep_sq(p.own[h], p.tgt[t], c) < longint'(c.strict_cut))
                  v.strict = 1'b1;
            end
         end
      end
      if (p.same)
         v.cls = CLASS_NONE;
      else if (strong_any)
         v.cls = CLASS_STRONG;
      else if (weak_any)
         v.cls = CLASS_WEAK;
      else
         v.cls = CLASS_NONE;
      return v;
   endfunction

   // ------------------------------------------------------------ stimulus

   function automatic pos_type pos3(int x, int y, int z);
      return {z[COORD_W-1:0], y[COORD_W-1:0], x[COORD_W-1:0]};
   endfunction

   function automatic pair_type make_pair(logic same, pos_type h1, pos_type h2,
                                          pos_type o1, pos_type o2, pos_type d1,
                                          pos_type d2, pos_type x1, pos_type x2);
      pair_type p;
      p.same   = same;
      p.hyd[0] = h1;
      p.hyd[1] = h2;
      p.own[0] = o1;
      p.own[1] = o2;
      p.tgt[0] = d1;
      p.tgt[1] = d2;
      p.tgt[2] = x1;
      p.tgt[3] = x2;
      return p;
   endfunction

   function automatic stim_row_type reg_row(logic [CSR_IDX_W-1:0] idx,
                                            logic [CUT_BITS-1:0] data);
      stim_row_type r;
      r        = '0;
      r.is_reg = 1'b1;
      r.idx    = idx;
      r.data   = data;
      return r;
   endfunction

   function automatic stim_row_type pair_row(pair_type p, logic pinned,
                                             bond_class_type cls, logic strict);
      stim_row_type r;
      r             = '0;
      r.pair        = p;
      r.pinned      = pinned;
      r.want.cls    = cls;
      r.want.strict = strict;
      return r;
   endfunction

   // spread below zero means anywhere in the box
   function automatic pos_type near_pos(cfg_type c, pos_type base, int spread);
      pos_type r;
      longint  v;
      longint  len;
      for (int a = 0; a < 3; a++) begin
         len = longint'(c.box[a]);
         if (spread < 0) begin
            if (len != 0)
               v = longint'($urandom_range(0, c.box[a] - 1));
            else
               v = longint'($urandom_range(0, BOX_MAX));
         end else begin
            v = longint'(base[COORD_W*a +: COORD_W])
                + longint'($urandom_range(0, 2 * spread)) - spread;
            if (len != 0)
               v = ((v % len) + len) % len;
            else
               v = v & longint'(BOX_MAX);
         end
         r[COORD_W*a +: COORD_W] = v[COORD_W-1:0];
      end
      return r;
   endfunction

   function automatic pair_type random_pair(cfg_type c);
      pair_type    p;
      logic [63:0] r;
      pos_type     centre;
      int          spread;
      if ($urandom_range(0, 6) == 0) begin
         p.same = 1'($urandom_range(0, 1));
         for (int i = 0; i < N_HYD; i++) begin
            r        = {$urandom, $urandom};
            p.hyd[i] = r[POS_W-1:0];
            r        = {$urandom, $urandom};
            p.own[i] = r[POS_W-1:0];
         end
         for (int t = 0; t < N_TGT; t++) begin
            r        = {$urandom, $urandom};
            p.tgt[t] = r[POS_W-1:0];
         end
      end else begin
         p.same = ($urandom_range(0, 7) == 0);
         case ($urandom_range(0, 3))
            0: spread = 200;
            1: spread = 800;
            2: spread = 2500;
            default: spread = 8000;
         endcase
         centre = near_pos(c, '0, -1);
         for (int i = 0; i < N_HYD; i++) begin
            p.hyd[i] = near_pos(c, centre, spread);
            p.own[i] = near_pos(c, p.hyd[i], 400);
         end
         for (int t = 0; t < N_TGT; t++)
            p.tgt[t] = near_pos(c, centre, spread);
      end
      return p;
   endfunction

   function automatic cfg_type phase_setting(int k);
      cfg_type c;
      c.periodic = 1'b1;
      for (int a = 0; a < 3; a++)
         c.box[a] = BOX_BITS'($urandom_range(4096, 40000));
      c.bond_cut   = CUT_BITS'($urandom_range(300000, 6000000));
      c.strict_cut = CUT_BITS'($urandom_range(1000000, 12000000));
      case (k)
         0: ;
         1: c.periodic = 1'b0;
         2: begin
            c.box        = {3{BOX_MAX}};
            c.bond_cut   = CUT_MAX;
            c.strict_cut = CUT_MAX;
         end
         3: c.box = '0;
         default: begin
            c.periodic = 1'($urandom_range(0, 1));
            for (int a = 0; a < 3; a++) begin
               case ($urandom_range(0, 5))
                  0: c.box[a] = '0;
                  1: c.box[a] = BOX_MAX;
                  default: ;
               endcase
            end
            case ($urandom_range(0, 9))
               0: c.bond_cut = '0;
               1: c.bond_cut = CUT_MAX;
               default: ;
            endcase
            case ($urandom_range(0, 9))
               0: c.strict_cut = '0;
               1: c.strict_cut = CUT_MAX;
               default: ;
            endcase
         end
      endcase
      return c;
   endfunction

   task automatic csr_drive(logic [CSR_IDX_W-1:0] idx, logic [CUT_BITS-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         REG_PERIODIC:   live_cfg.periodic   = data[0];
         REG_BOX_X:      live_cfg.box[0]     = data[BOX_BITS-1:0];
         REG_BOX_Y:      live_cfg.box[1]     = data[BOX_BITS-1:0];
         REG_BOX_Z:      live_cfg.box[2]     = data[BOX_BITS-1:0];
         REG_BOND_CUT:   live_cfg.bond_cut   = data;
         REG_STRICT_CUT: live_cfg.strict_cut = data;
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic write_all(cfg_type c);
      csr_drive(REG_PERIODIC, CUT_BITS'(c.periodic));
      csr_drive(REG_BOX_X, CUT_BITS'(c.box[0]));
      csr_drive(REG_BOX_Y, CUT_BITS'(c.box[1]));
      csr_drive(REG_BOX_Z, CUT_BITS'(c.box[2]));
      csr_drive(REG_BOND_CUT, c.bond_cut);
      csr_drive(REG_STRICT_CUT, c.strict_cut);
      csr_we <= 1'b0;
   endtask

   // stop offering and let every outstanding beat drain
   task automatic hold_input();
      req_valid <= 1'b0;
      @(negedge clock);
      while (due_verdicts.size() != 0)
         @(negedge clock);
      @(posedge clock);
   endtask

   task automatic offer_pair(pair_type p, logic pinned, verdict_type want);
      int      gap;
      pin_type note;
      if ($urandom_range(0, 39) == 0)
         send_calm = !send_calm;
      gap = send_calm ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      note.pinned = pinned;
      note.want   = want;
      pinned_verdicts.push_back(note);
      req_valid          <= 1'b1;
      req_same_molecule  <= p.same;
      req_a_hydrogen_one <= p.hyd[0];
      req_a_hydrogen_two <= p.hyd[1];
      req_a_hydroxyl_one <= p.own[0];
      req_a_hydroxyl_two <= p.own[1];
      req_b_double_one   <= p.tgt[0];
      req_b_double_two   <= p.tgt[1];
      req_b_hydroxyl_one <= p.tgt[2];
      req_b_hydroxyl_two <= p.tgt[3];
      do
         @(posedge clock);
      while (!req_ready);
   endtask

   initial begin
      pos_type p;
      pos_type q;
      pos_type h;
      pos_type t;
      logic    csr_open;
      live_cfg          = '0;
      live_cfg.periodic = 1'b1;
      csr_open          = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      p = pos3(5000, 6000, 7000);
      q = pos3(9096, 6000, 7000);
      // reset values: zero cutoffs, nothing can touch
      stim_table.push_back(pair_row(make_pair(0, '0, '0, '0, '0, '0, '0, '0, '0),
                                    1, CLASS_NONE, 0));
      stim_table.push_back(pair_row(make_pair(0, ONES, ONES, ONES, ONES, ONES, ONES,
                                              ONES, ONES), 1, CLASS_NONE, 0));
      stim_table.push_back(reg_row(REG_PERIODIC, 0));
      stim_table.push_back(reg_row(REG_BOX_X, 12288));
      stim_table.push_back(reg_row(REG_BOX_Y, 12288));
      stim_table.push_back(reg_row(REG_BOX_Z, 12288));
      stim_table.push_back(reg_row(REG_BOND_CUT, 1048576));
      stim_table.push_back(reg_row(REG_STRICT_CUT, 4194304));
      stim_table.push_back(pair_row(make_pair(0, p, p, p, p, p, p, p, p),
                                    1, CLASS_STRONG, 1));
      stim_table.push_back(pair_row(make_pair(1, p, p, p, p, p, p, p, p),
                                    1, CLASS_NONE, 1));
      stim_table.push_back(pair_row(make_pair(0, ONES, ONES, ONES, ONES, ONES, ONES,
                                              ONES, ONES), 1, CLASS_STRONG, 1));
      stim_table.push_back(pair_row(make_pair(0, p, p, p, p, q, q, p, p),
                                    0, CLASS_NONE, 0));
      stim_table.push_back(pair_row(make_pair(0, '0, '0, ONES, ONES, ONES, ONES,
                                              ONES, ONES), 0, CLASS_NONE, 0));
      stim_table.push_back(pair_row(make_pair(0, '0, '0, ONES, ONES, '0, ONES,
                                              '0, ONES), 0, CLASS_NONE, 0));
      stim_table.push_back(pair_row(make_pair(0, p, p, q, q, p, p, p, p),
                                    0, CLASS_NONE, 0));
      stim_table.push_back(reg_row(REG_PERIODIC, 1));
      h = pos3(100, 6000, 7000);
      t = pos3(12188, 6000, 7000);
      stim_table.push_back(pair_row(make_pair(0, h, h, h, h, t, t, t, t),
                                    0, CLASS_NONE, 0));
      stim_table.push_back(pair_row(make_pair(0, pos3(5000, 50, 12250), q, q, q,
                                              pos3(5000, 12200, 30), q, q, q),
                                    0, CLASS_NONE, 0));
      // exactly half a box apart, and one step past it
      stim_table.push_back(pair_row(make_pair(0, pos3(0, 6000, 7000), q, q, q,
                                              pos3(6144, 6000, 7000),
                                              pos3(6145, 6000, 7000), q, q),
                                    0, CLASS_NONE, 0));
      stim_table.push_back(reg_row(REG_BOX_X, 0));
      stim_table.push_back(reg_row(REG_BOX_Y, 0));
      stim_table.push_back(reg_row(REG_BOX_Z, 0));
      stim_table.push_back(pair_row(make_pair(0, h, h, h, h, t, t, t, t),
                                    0, CLASS_NONE, 0));
      stim_table.push_back(reg_row(REG_BOX_X, CUT_BITS'(BOX_MAX)));
      stim_table.push_back(reg_row(REG_BOX_Y, CUT_BITS'(BOX_MAX)));
      stim_table.push_back(reg_row(REG_BOX_Z, CUT_BITS'(BOX_MAX)));
      stim_table.push_back(pair_row(make_pair(0, '0, '0, '0, '0, ONES, ONES, ONES, ONES),
                                    0, CLASS_NONE, 0));
      stim_table.push_back(reg_row(REG_BOND_CUT, CUT_MAX));
      stim_table.push_back(reg_row(REG_STRICT_CUT, CUT_MAX));
      stim_table.push_back(pair_row(make_pair(0, '0, '0, '0, '0, ONES, ONES, ONES, ONES),
                                    1, CLASS_STRONG, 1));
      stim_table.push_back(pair_row(make_pair(1, '0, '0, '0, '0, ONES, ONES, ONES, ONES),
                                    1, CLASS_NONE, 1));
      stim_table.push_back(reg_row(REG_STRICT_CUT, 0));
      stim_table.push_back(pair_row(make_pair(0, p, p, p, p, p, p, p, p),
                                    1, CLASS_STRONG, 0));
      stim_table.push_back(reg_row(REG_BOND_CUT, 0));
      stim_table.push_back(reg_row(REG_STRICT_CUT, CUT_MAX));
      stim_table.push_back(pair_row(make_pair(0, p, p, p, p, p, p, p, p),
                                    1, CLASS_NONE, 0));

      foreach (stim_table[i]) begin
         if (stim_table[i].is_reg) begin
            if (!csr_open) begin
               hold_input();
               csr_open = 1'b1;
            end
            csr_drive(stim_table[i].idx, stim_table[i].data);
         end else begin
            if (csr_open) begin
               csr_we  <= 1'b0;
               csr_open = 1'b0;
            end
            offer_pair(stim_table[i].pair, stim_table[i].pinned, stim_table[i].want);
         end
      end

      for (int k = 0; k < PHASES; k++) begin
         hold_input();
         write_all(phase_setting(k));
         for (int n = 0; n < PHASE_BEATS; n++) begin
            if (k == 5 && n == 10)
               hold_asked = 1'b1;
            offer_pair(random_pair(live_cfg), 1'b0, '0);
         end
      end

      hold_input();
      repeat (2 * PIPE_DEPTH) @(posedge clock);
      if (failures == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // result side back-pressure
   initial begin
      int stall;
      while (reset)
         @(posedge clock);
      forever begin
         if ($urandom_range(0, 39) == 0)
            sink_calm = !sink_calm;
         stall = sink_calm ? 0 : $urandom_range(0, 12);
         if (hold_asked) begin
            hold_asked = 1'b0;
            stall      = HOLD_CYCLES;
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do
            @(posedge clock);
         while (!rsp_valid);
      end
   end

   // ------------------------------------------------------------- checking

   always @(posedge clock) begin : beat_check
      verdict_type want;
      pin_type     note;
      pair_type    seen;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (due_verdicts.size() == 0) begin
               $error("unexpected result beat: bond_class %0d strict_bond %0d",
                      rsp_bond_class, rsp_strict_bond);
               failures++;
            end else begin
               want = due_verdicts.pop_front();
               if (rsp_bond_class !== want.cls) begin
                  $error("bond_class: expected %0d, got %0d", want.cls, rsp_bond_class);
                  failures++;
               end
               if (rsp_strict_bond !== want.strict) begin
                  $error("strict_bond: expected %0d, got %0d", want.strict,
                         rsp_strict_bond);
                  failures++;
               end
            end
         end
         if (req_valid && req_ready) begin
            note = pinned_verdicts.pop_front();
            seen = make_pair(req_same_molecule, req_a_hydrogen_one, req_a_hydrogen_two,
                             req_a_hydroxyl_one, req_a_hydroxyl_two, req_b_double_one,
                             req_b_double_two, req_b_hydroxyl_one, req_b_hydroxyl_two);
            if (note.pinned)
               due_verdicts.push_back(note.want);
            else
               due_verdicts.push_back(classify_pair(seen, live_cfg));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule
